// ===== rtl/ncr_pkg.sv =====
// ----------------------------------------------------------------------------
// ncr_pkg
// Shared widths, status codes and defaults of the numeric character
// reference decoder.
// ----------------------------------------------------------------------------
package ncr_pkg;

    localparam int CHAR_W = 16;
    localparam int CODE_W = 16;

    // Code limit that every accumulated code stays below (exclusive bound of the limit test)
    localparam logic [31:0] CODE_MAX_DEFAULT = 32'd65535;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_HEX = 2'd1,
        ST_BAD_DEC = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

endpackage

// ===== rtl/ncr_if.sv =====
// ----------------------------------------------------------------------------
// ncr_if
// Valid/ready channels of the numeric character reference decoder: one for
// digit characters, one for decoded codes.
// ----------------------------------------------------------------------------
interface ncr_char_if;

    logic                        valid;
    logic                        ready;
    logic [ncr_pkg::CHAR_W-1:0]  char_in;
    logic                        hex_mode;
    logic                        last_char;

    modport source (output valid, output char_in, output hex_mode, output last_char,
                    input ready);
    modport sink   (input valid, input char_in, input hex_mode, input last_char,
                    output ready);

endinterface

interface ncr_code_if;

    logic                        valid;
    logic                        ready;
    logic [ncr_pkg::CODE_W-1:0]  code_value;
    ncr_pkg::t_status            status;

    modport source (output valid, output code_value, output status, input ready);
    modport sink   (input valid, input code_value, input status, output ready);

endinterface

// ===== rtl/numeric_char_ref_decoder_core.sv =====
// ----------------------------------------------------------------------------
// numeric_char_ref_decoder_core
// Decodes the digits of a numeric character reference, one character per
// request, into a code value and a status on the last character.
// ----------------------------------------------------------------------------
//  channel  | dir | modport | payload
//  i_req    | in  | sink    | char_in[15:0], hex_mode, last_char
//  o_res    | out | source  | code_value[15:0], status[1:0]
//
//  One character per cycle unless a stalled result holds a last character:
//  a request is registered, then decoded combinationally against the
//  accumulator; the decode stage holds the reference state. The result
//  register loads once it is free and the last character is in the input
//  register. i_rst_n (synchronous, active low) clears the reference state
//  and both valid flags. A stalled result holds the decode stage only when
//  the next character is a last one; other characters keep flowing.
// ----------------------------------------------------------------------------
module numeric_char_ref_decoder_core #(
    parameter logic [31:0] CODE_MAX = ncr_pkg::CODE_MAX_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ncr_char_if.sink       i_req,
    ncr_code_if.source     o_res
);

    localparam int ACC_W = $clog2(CODE_MAX);
    localparam int EXT_W = ACC_W + 5;

    localparam logic [ncr_pkg::CHAR_W-1:0] CHAR_0    = 16'h0030;
    localparam logic [ncr_pkg::CHAR_W-1:0] CHAR_9    = 16'h0039;
    localparam logic [ncr_pkg::CHAR_W-1:0] CHAR_LC_A = 16'h0061;
    localparam logic [ncr_pkg::CHAR_W-1:0] CHAR_LC_F = 16'h0066;
    localparam logic [ncr_pkg::CHAR_W-1:0] CHAR_UC_A = 16'h0041;
    localparam logic [ncr_pkg::CHAR_W-1:0] CHAR_UC_F = 16'h0046;

    // input register
    logic                        r_in_valid;
    logic [ncr_pkg::CHAR_W-1:0]  r_in_char;
    logic                        r_in_hex;
    logic                        r_in_last;

    // reference state
    logic [ACC_W-1:0]            r_acc;
    logic                        r_hex;
    logic                        r_mid;
    ncr_pkg::t_status            r_err;

    // result register
    logic                        r_out_valid;
    logic [ncr_pkg::CODE_W-1:0]  r_out_code;
    ncr_pkg::t_status            r_out_status;

    logic                        w_out_free;
    logic                        w_adv;
    logic                        w_hex;
    logic [ACC_W-1:0]            w_acc0;
    ncr_pkg::t_status            w_err0;
    logic                        w_dig_ok;
    logic [3:0]                  w_dig;
    logic [EXT_W-1:0]            w_acc_ext;
    logic [EXT_W-1:0]            w_prod;
    logic [EXT_W-1:0]            w_next;
    logic [EXT_W-1:0]            w_test;
    logic                        w_over;
    logic [ACC_W-1:0]            n_acc;
    ncr_pkg::t_status            n_err;
    ncr_pkg::t_status            w_fin_status;
    logic [ncr_pkg::CODE_W-1:0]  w_fin_code;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_adv       = r_in_valid && (!r_in_last || w_out_free);
    assign i_req.ready = !r_in_valid || w_adv;

    assign o_res.valid      = r_out_valid;
    assign o_res.code_value = r_out_code;
    assign o_res.status     = r_out_status;

    // first character of a reference starts from a clean state
    assign w_hex  = r_mid ? r_hex : r_in_hex;
    assign w_acc0 = r_mid ? r_acc : '0;
    assign w_err0 = r_mid ? r_err : ncr_pkg::ST_OK;

    always_comb begin
        w_dig_ok = 1'b0;
        w_dig    = 4'd0;
        if (r_in_char >= CHAR_0 && r_in_char <= CHAR_9) begin
            w_dig_ok = 1'b1;
            w_dig    = 4'(r_in_char - CHAR_0);
        end else if (w_hex && r_in_char >= CHAR_LC_A && r_in_char <= CHAR_LC_F) begin
            w_dig_ok = 1'b1;
            w_dig    = 4'(r_in_char - CHAR_LC_A + 16'd10);
        end else if (w_hex && r_in_char >= CHAR_UC_A && r_in_char <= CHAR_UC_F) begin
            w_dig_ok = 1'b1;
            w_dig    = 4'(r_in_char - CHAR_UC_A + 16'd10);
        end
    end

    // acc >= (CODE_MAX - d) / radix  <=>  acc*radix + radix + d > CODE_MAX
    assign w_acc_ext = EXT_W'(w_acc0);
    assign w_prod    = w_hex ? (w_acc_ext << 4) : ((w_acc_ext << 3) + (w_acc_ext << 1));
    assign w_next    = w_prod + EXT_W'(w_dig);
    assign w_test    = w_next + (w_hex ? EXT_W'(16) : EXT_W'(10));
    assign w_over    = w_test > EXT_W'(CODE_MAX);

    always_comb begin
        n_acc = w_acc0;
        n_err = w_err0;
        if (w_err0 == ncr_pkg::ST_OK) begin
            if (!w_dig_ok) begin
                n_err = w_hex ? ncr_pkg::ST_BAD_HEX : ncr_pkg::ST_BAD_DEC;
            end else if (w_over) begin
                n_err = ncr_pkg::ST_INVALID;
            end else begin
                n_acc = ACC_W'(w_next);
            end
        end
    end

    always_comb begin
        w_fin_status = n_err;
        if (n_err == ncr_pkg::ST_OK && n_acc == '0) begin
            w_fin_status = ncr_pkg::ST_INVALID;
        end
        w_fin_code = (w_fin_status == ncr_pkg::ST_OK) ? ncr_pkg::CODE_W'(n_acc) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_acc       <= '0;
            r_hex       <= 1'b0;
            r_mid       <= 1'b0;
            r_err       <= ncr_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            // capture a new request or drain the input register
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
                r_in_char  <= i_req.char_in;
                r_in_hex   <= i_req.hex_mode;
                r_in_last  <= i_req.last_char;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end

            if (w_adv) begin
                if (r_in_last) begin
                    r_mid <= 1'b0;
                    r_acc <= '0;
                    r_err <= ncr_pkg::ST_OK;
                end else begin
                    r_mid <= 1'b1;
                    r_hex <= w_hex;
                    r_acc <= n_acc;
                    r_err <= n_err;
                end
            end

            if (w_adv && r_in_last) begin
                r_out_valid  <= 1'b1;
                r_out_code   <= w_fin_code;
                r_out_status <= w_fin_status;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        33'(r_acc) < 33'(CODE_MAX))
        else $error("accumulator reached the code limit");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mid |-> (r_acc == '0 && r_err == ncr_pkg::ST_OK))
        else $error("state left over outside a reference");

    a_err_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ncr_pkg::ST_OK) |-> r_out_code == '0)
        else $error("code value set on a failed reference");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_out_code)
            && $stable(r_out_status)))
        else $error("pending result lost or changed");
`endif

endmodule

// ===== bench/tb_numeric_char_ref_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_numeric_char_ref_decoder_core
// Self-checking bench for the numeric character reference decoder. Digit
// characters go in on the request channel with random gaps. Each request is
// run through a local model of the accumulate, limit and status rules, and
// the codes it predicts are checked in order against the result channel.
// The result side stalls at random. A directed set of references comes
// first, then random references.
// ----------------------------------------------------------------------------
module tb_numeric_char_ref_decoder_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_GAP        = 16;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        logic [ncr_pkg::CODE_W-1:0] code;
        ncr_pkg::t_status           status;
    } t_code_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ncr_char_if req_if ();
    ncr_code_if res_if ();

    numeric_char_ref_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Decoder state as the bench sees it
    int unsigned       code_acc;
    logic              radix_is_hex;
    logic              in_reference;
    ncr_pkg::t_status  latched_status;

    t_code_result expected_codes[$];
    int           error_count;
    int           chars_sent;
    int           stall_cycles;
    bit           no_gaps;

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // ------------------------------------------------------------------------
    // Decode model: one accepted character in, at most one code out
    // ------------------------------------------------------------------------
    task automatic decode_char(input logic [ncr_pkg::CHAR_W-1:0] c, input logic hex,
                               input logic last);
        int           dig;
        int unsigned  radix;
        int unsigned  bound;
        t_code_result res;
        if (!in_reference) begin
            code_acc       = 0;
            latched_status = ncr_pkg::ST_OK;
            radix_is_hex   = hex;
            in_reference   = 1'b1;
        end
        if (latched_status == ncr_pkg::ST_OK) begin
            dig = -1;
            if (c >= 16'h0030 && c <= 16'h0039)
                dig = int'(c) - 'h30;
            else if (radix_is_hex && c >= 16'h0061 && c <= 16'h0066)
                dig = int'(c) - 'h61 + 10;
            else if (radix_is_hex && c >= 16'h0041 && c <= 16'h0046)
                dig = int'(c) - 'h41 + 10;
            if (dig < 0) begin
                latched_status = radix_is_hex ? ncr_pkg::ST_BAD_HEX : ncr_pkg::ST_BAD_DEC;
            end else begin
                radix = radix_is_hex ? 16 : 10;
                bound = (int'(ncr_pkg::CODE_MAX_DEFAULT) - dig) / radix;
                if (code_acc >= bound)
                    latched_status = ncr_pkg::ST_INVALID;
                else
                    code_acc = code_acc * radix + dig;
            end
        end
        if (last) begin
            res.status = latched_status;
            res.code   = '0;
            if (res.status == ncr_pkg::ST_OK && code_acc == 0)
                res.status = ncr_pkg::ST_INVALID;
            if (res.status == ncr_pkg::ST_OK)
                res.code = code_acc[ncr_pkg::CODE_W-1:0];
            expected_codes.push_back(res);
            in_reference   = 1'b0;
            code_acc       = 0;
            latched_status = ncr_pkg::ST_OK;
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [ncr_pkg::CHAR_W-1:0] c, input logic hex,
                             input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.char_in   <= c;
        req_if.hex_mode  <= hex;
        req_if.last_char <= last;
        do @(posedge i_clk); while (!req_if.ready);
        decode_char(c, hex, last);
        chars_sent++;
    endtask

    // Send an ASCII string as one reference; optionally flip hex_mode
    // on the characters after the first.
    task automatic send_text(input string s, input bit hex, input bit flip_later);
        logic h;
        for (int i = 0; i < s.len(); i++) begin
            h = (i > 0 && flip_later) ? !hex : hex;
            send_char({8'h00, s[i]}, h, i == s.len() - 1);
        end
    endtask

    // Format a value as a well-formed reference with random letter case and
    // leading zeros.
    task automatic send_value(input int unsigned val, input bit hex);
        byte unsigned digs[$];
        int unsigned  radix;
        int unsigned  v;
        int unsigned  d;
        int           pad;
        radix = hex ? 16 : 10;
        v     = val;
        do begin
            d = v % radix;
            if (d < 10)
                digs.push_front(8'(8'h30 + d));
            else
                digs.push_front(8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + d - 10));
            v = v / radix;
        end while (v != 0);
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (pad) digs.push_front(8'h30);
        foreach (digs[i])
            send_char({8'h00, digs[i]}, (i == 0) ? hex : 1'($urandom_range(0, 1)),
                      i == digs.size() - 1);
    endtask

    function automatic logic [ncr_pkg::CHAR_W-1:0] noise_char();
        case ($urandom_range(0, 4))
            0: return 16'(16'h0030 + $urandom_range(0, 9));
            1: return 16'(16'h0061 + $urandom_range(0, 5));
            2: return 16'(16'h0041 + $urandom_range(0, 5));
            3: return 16'($urandom_range(0, 16'hFFFF));
            default: return 16'(16'h0020 + $urandom_range(0, 16'h5F));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, in-order compare
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            stall_cycles = draw_gap();
            if (stall_cycles > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall_cycles) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
        end
    end

    always @(posedge i_clk) begin
        t_code_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_codes.size() == 0) begin
                $error("unexpected result: code_value %0d, status %0d",
                       res_if.code_value, res_if.status);
                error_count++;
            end else begin
                exp_res = expected_codes.pop_front();
                if (res_if.code_value !== exp_res.code) begin
                    $error("code_value: expected %0d, got %0d",
                           exp_res.code, res_if.code_value);
                    error_count++;
                end
                if (res_if.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d",
                           exp_res.status, res_if.status);
                    error_count++;
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        no_gaps = 1'b0;
        send_text("0", 1'b1, 1'b0);        // zero value
        send_text("FFEF", 1'b1, 1'b0);     // largest hex code that passes
        send_text("FFF0", 1'b1, 1'b0);     // hex limit trips
        send_text("65524", 1'b0, 1'b0);    // largest decimal with digit 4
        send_text("65529", 1'b0, 1'b0);    // decimal limit trips
        send_text("aB", 1'b1, 1'b1);       // mixed case, hex_mode flips later
        send_text("g1", 1'b1, 1'b0);       // bad hex digit, rest ignored
        send_text("1a", 1'b0, 1'b0);       // letter in decimal
        send_char(16'hFFFF, 1'b1, 1'b1);   // all ones
        send_char(16'h0130, 1'b0, 1'b1);   // digit in low byte only
        send_text("9", 1'b0, 1'b0);
    endtask

    task automatic test_random_refs();
        int unsigned val;
        int          len;
        bit          hex;
        while (chars_sent < RANDOM_ITEMS) begin
            // Alternate stretches with and without gaps
            if ($urandom_range(0, 15) == 0)
                no_gaps = !no_gaps;
            hex = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 3))
                    0: val = $urandom_range(0, 255);
                    1: val = $urandom_range(65500, 65535);
                    2: val = $urandom_range(0, hex ? 16'hFFFF : 9999);
                    default: val = $urandom_range(0, 65535);
                endcase
                send_value(val, hex);
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_char(noise_char(), (i == 0) ? hex : 1'($urandom_range(0, 1)),
                              i == len - 1);
            end
        end
        req_if.valid <= 1'b0;
    endtask

    initial begin
        error_count    = 0;
        chars_sent     = 0;
        no_gaps        = 1'b0;
        code_acc       = 0;
        radix_is_hex   = 1'b0;
        in_reference   = 1'b0;
        latched_status = ncr_pkg::ST_OK;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.char_in   <= '0;
        req_if.hex_mode  <= 1'b0;
        req_if.last_char <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_refs();

        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
